// ===== src/gmft_pkg.sv =====
// gmft_pkg: shared widths, request, command and status codes, and the
// command and result records of the group membership fanout table.
// No dependencies; gmft_front, gmft_back and the top level import it.
package gmft_pkg;

    // parameter defaults
    localparam int GROUPS_DEF  = 32;
    localparam int SLOTS_DEF   = 32;
    localparam int ID_BITS_DEF = 16;

    // fixed field widths
    localparam int REQ_W    = 2;
    localparam int GRP_W    = 8;
    localparam int ID_W     = 16;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 5;
    localparam int OP_W     = 2;

    // queue depths between the parts
    localparam int CMD_DEPTH = 2;
    localparam int RES_DEPTH = 4;

    // request types on the input
    localparam logic [REQ_W-1:0] REQ_JOIN   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_LEAVE  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_SEND   = 2'd2;
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    // classified commands handed to the back end
    localparam logic [OP_W-1:0] CMD_JOIN  = 2'd0;
    localparam logic [OP_W-1:0] CMD_LEAVE = 2'd1;
    localparam logic [OP_W-1:0] CMD_SEND  = 2'd2;
    localparam logic [OP_W-1:0] CMD_BAD   = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_ALREADY    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL       = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_MEMBER = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BAD_GROUP  = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [GRP_W-1:0] grp;
        logic [ID_W-1:0]  id;
    } cmd_t;

    // head of the command queue as seen by the back end
    typedef struct packed {
        logic avail;
        cmd_t cmd;
    } cmd_head_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                dest_valid;
        logic [ID_W-1:0]     dest_id;
        logic [SLOT_W-1:0]   slot_index;
        logic                last;
    } res_t;

    localparam int CMD_BITS = $bits(cmd_t);
    localparam int RES_BITS = $bits(res_t);

endpackage

// ===== src/gmft_fifo.sv =====
// gmft_fifo: small first-in first-out queue of register entries with
// full and empty flags; used for the command queue and the result queue.
// No package dependencies.
module gmft_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == DEPTH_C);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = entry_reg[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ===== src/gmft_front.sv =====
// gmft_front: accepts requests, drops the unused request type, rejects
// out-of-range groups, masks the id and queues a command for the back end.
// Depends on gmft_pkg and gmft_fifo.
module gmft_front #(
    parameter int GROUPS  = gmft_pkg::GROUPS_DEF,
    parameter int ID_BITS = gmft_pkg::ID_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic [gmft_pkg::REQ_W-1:0]   req_type,
    input  logic [gmft_pkg::GRP_W-1:0]   group_index,
    input  logic [gmft_pkg::ID_W-1:0]    member_id,
    input  logic                         cmd_pop,
    output gmft_pkg::cmd_head_t          cmd_head
);

    import gmft_pkg::*;

    localparam logic [GRP_W:0] GROUP_LIM = (GRP_W + 1)'(GROUPS);
    localparam logic [ID_W-1:0] ID_MASK =
        (ID_BITS >= ID_W) ? {ID_W{1'b1}} : ID_W'((64'd1 << ID_BITS) - 64'd1);

    cmd_t             cmd_in;
    logic             q_push;
    logic             q_empty;
    logic [CMD_BITS-1:0] q_rdata;

    // classify the incoming request
    always_comb
    begin
        cmd_in.grp = group_index;
        cmd_in.id  = member_id & ID_MASK;
        case (req_type)
            REQ_JOIN:  cmd_in.op = CMD_JOIN;
            REQ_LEAVE: cmd_in.op = CMD_LEAVE;
            default:   cmd_in.op = CMD_SEND;
        endcase
        if ({1'b0, group_index} >= GROUP_LIM)
        begin
            cmd_in.op = CMD_BAD;
        end
    end

    // unused request type is taken and dropped
    assign q_push = push && !full && (req_type != REQ_UNUSED);

    gmft_fifo #(
        .WIDTH (CMD_BITS),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (cmd_in),
        .full  (full),
        .pop   (cmd_pop),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    assign cmd_head.avail = !q_empty;
    assign cmd_head.cmd   = q_rdata;

endmodule

// ===== src/gmft_back.sv =====
// gmft_back: holds the group table and runs one command at a time: row
// read, member search, update, and the fanout walk for send requests.
// Depends on gmft_pkg.
module gmft_back #(
    parameter int GROUPS  = gmft_pkg::GROUPS_DEF,
    parameter int SLOTS   = gmft_pkg::SLOTS_DEF,
    parameter int ID_BITS = gmft_pkg::ID_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  gmft_pkg::cmd_head_t cmd_head,
    output logic                cmd_pop,
    input  logic                res_full,
    output logic                res_push,
    output gmft_pkg::res_t      res_data
);

    import gmft_pkg::*;

    localparam int MEM_W = (ID_BITS < ID_W) ? ID_BITS : ID_W;
    localparam int SI_W  = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int GI_W  = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int DEPTH = GROUPS * SLOTS;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [AW-1:0]   SLOTS_A   = AW'(SLOTS);
    localparam logic [SI_W-1:0] LAST_SLOT = SI_W'(SLOTS - 1);

    // sequencer states
    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_ROW     = 3'd1;
    localparam logic [2:0] S_FIND    = 3'd2;
    localparam logic [2:0] S_FAN     = 3'd3;
    localparam logic [2:0] S_FAN_END = 3'd4;
    localparam logic [2:0] S_EMIT    = 3'd5;

    // table storage: one in-use row per group, one member id per slot
    logic [SLOTS-1:0] row_mem [GROUPS];
    logic [MEM_W-1:0] mem [DEPTH];

    logic [2:0]       state_reg, state_next;
    logic [GROUPS-1:0] row_vld_reg, row_vld_next;
    logic             free_vld_reg, free_vld_next;
    logic             pend_vld_reg, pend_vld_next;
    logic [CNT_W-1:0] scan_reg, scan_next;

    logic [OP_W-1:0]  op_reg, op_next;
    logic [GI_W-1:0]  gi_reg, gi_next;
    logic [MEM_W-1:0] id_reg, id_next;
    logic [AW-1:0]    base_reg, base_next;
    logic [SLOTS-1:0] row_reg, row_next;
    logic [SLOTS-1:0] row_q_reg;
    logic [MEM_W-1:0] mem_q_reg;
    logic [SI_W-1:0]  q_slot_reg;
    logic [SI_W-1:0]  free_slot_reg, free_slot_next;
    logic [SI_W-1:0]  pend_slot_reg, pend_slot_next;
    logic [MEM_W-1:0] pend_id_reg, pend_id_next;
    res_t             res_reg, res_next;

    logic [CNT_W-1:0] rd_slot;
    logic [AW-1:0]    rd_addr;
    logic             row_we;
    logic [SLOTS-1:0] row_wdata;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic             hit_find, hit_fan, q_is_last, fan_stall;
    logic             free_now;
    logic [SI_W-1:0]  free_at;

    function automatic res_t make_res(
        input logic [STATUS_W-1:0] st,
        input logic                dv,
        input logic [ID_W-1:0]     did,
        input logic [SLOT_W-1:0]   sl,
        input logic                lst
    );
        res_t r;
        r.status     = st;
        r.dest_valid = dv;
        r.dest_id    = did;
        r.slot_index = sl;
        r.last       = lst;
        return r;
    endfunction

    // slot checks on the member read that just returned
    assign hit_find  = row_reg[q_slot_reg] && (mem_q_reg == id_reg);
    assign hit_fan   = row_reg[q_slot_reg] && (mem_q_reg != id_reg);
    assign q_is_last = (q_slot_reg == LAST_SLOT);
    assign fan_stall = hit_fan && pend_vld_reg && res_full;
    assign free_now  = free_vld_reg || !row_reg[q_slot_reg];
    assign free_at   = free_vld_reg ? free_slot_reg : q_slot_reg;
    assign rd_addr   = base_reg + AW'(rd_slot);

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        row_vld_next   = row_vld_reg;
        free_vld_next  = free_vld_reg;
        pend_vld_next  = pend_vld_reg;
        scan_next      = scan_reg;
        op_next        = op_reg;
        gi_next        = gi_reg;
        id_next        = id_reg;
        base_next      = base_reg;
        row_next       = row_reg;
        free_slot_next = free_slot_reg;
        pend_slot_next = pend_slot_reg;
        pend_id_next   = pend_id_reg;
        res_next       = res_reg;
        cmd_pop        = 1'b0;
        res_push       = 1'b0;
        res_data       = res_reg;
        rd_slot        = scan_reg;
        row_we         = 1'b0;
        row_wdata      = row_reg;
        mem_we         = 1'b0;
        mem_waddr      = base_reg + AW'(free_at);

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_head.avail)
                begin
                    cmd_pop       = 1'b1;
                    op_next       = cmd_head.cmd.op;
                    gi_next       = cmd_head.cmd.grp[GI_W-1:0];
                    id_next       = cmd_head.cmd.id[MEM_W-1:0];
                    base_next     = AW'(cmd_head.cmd.grp[GI_W-1:0]) * SLOTS_A;
                    scan_next     = '0;
                    free_vld_next = 1'b0;
                    pend_vld_next = 1'b0;
                    if (cmd_head.cmd.op == CMD_BAD)
                    begin
                        res_next   = make_res(ST_BAD_GROUP, 1'b0, '0, '0, 1'b1);
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        state_next = S_ROW;
                    end
                end
            end

            // row is back; start the member search at slot zero
            S_ROW:
            begin
                row_next   = row_q_reg & {SLOTS{row_vld_reg[gi_reg]}};
                scan_next  = scan_reg + CNT_W'(1);
                state_next = S_FIND;
            end

            S_FIND:
            begin
                if (!row_reg[q_slot_reg] && !free_vld_reg)
                begin
                    free_vld_next  = 1'b1;
                    free_slot_next = q_slot_reg;
                end
                if (hit_find)
                begin
                    // member found: joiner, leaver or sender
                    case (op_reg)
                        CMD_JOIN:
                        begin
                            res_next = make_res(ST_ALREADY, 1'b0, '0,
                                                SLOT_W'(q_slot_reg), 1'b1);
                            state_next = S_EMIT;
                        end
                        CMD_LEAVE:
                        begin
                            row_we              = 1'b1;
                            row_wdata[q_slot_reg] = 1'b0;
                            res_next = make_res(ST_OK, 1'b0, '0,
                                                SLOT_W'(q_slot_reg), 1'b1);
                            state_next = S_EMIT;
                        end
                        default:
                        begin
                            // restart the walk for the fanout pass
                            rd_slot       = '0;
                            scan_next     = CNT_W'(1);
                            pend_vld_next = 1'b0;
                            state_next    = S_FAN;
                        end
                    endcase
                end
                else if (q_is_last)
                begin
                    // id not in the group
                    case (op_reg)
                        CMD_JOIN:
                        begin
                            if (free_now)
                            begin
                                mem_we             = 1'b1;
                                row_we             = 1'b1;
                                row_wdata[free_at] = 1'b1;
                                res_next = make_res(ST_OK, 1'b0, '0,
                                                    SLOT_W'(free_at), 1'b1);
                            end
                            else
                            begin
                                res_next = make_res(ST_FULL, 1'b0, '0, '0, 1'b1);
                            end
                        end
                        default:
                        begin
                            res_next = make_res(ST_NOT_MEMBER, 1'b0, '0, '0, 1'b1);
                        end
                    endcase
                    state_next = S_EMIT;
                end
                else
                begin
                    scan_next = scan_reg + CNT_W'(1);
                end
            end

            // one-deep lookahead so the final destination carries last
            S_FAN:
            begin
                if (fan_stall)
                begin
                    rd_slot = CNT_W'(q_slot_reg);
                end
                else
                begin
                    if (hit_fan)
                    begin
                        if (pend_vld_reg)
                        begin
                            res_push = 1'b1;
                            res_data = make_res(ST_OK, 1'b1, ID_W'(pend_id_reg),
                                                SLOT_W'(pend_slot_reg), 1'b0);
                        end
                        pend_vld_next  = 1'b1;
                        pend_slot_next = q_slot_reg;
                        pend_id_next   = mem_q_reg;
                    end
                    if (q_is_last)
                    begin
                        state_next = S_FAN_END;
                    end
                    else
                    begin
                        scan_next = scan_reg + CNT_W'(1);
                    end
                end
            end

            S_FAN_END:
            begin
                if (pend_vld_reg)
                begin
                    res_data = make_res(ST_OK, 1'b1, ID_W'(pend_id_reg),
                                        SLOT_W'(pend_slot_reg), 1'b1);
                end
                else
                begin
                    res_data = make_res(ST_OK, 1'b0, '0, '0, 1'b1);
                end
                if (!res_full)
                begin
                    res_push   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            S_EMIT:
            begin
                if (!res_full)
                begin
                    res_push   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (row_we)
        begin
            row_vld_next[gi_reg] = 1'b1;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            row_vld_reg  <= '0;
            free_vld_reg <= 1'b0;
            pend_vld_reg <= 1'b0;
            scan_reg     <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            row_vld_reg  <= row_vld_next;
            free_vld_reg <= free_vld_next;
            pend_vld_reg <= pend_vld_next;
            scan_reg     <= scan_next;
        end
    end

    // command and result payload
    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        gi_reg        <= gi_next;
        id_reg        <= id_next;
        base_reg      <= base_next;
        row_reg       <= row_next;
        free_slot_reg <= free_slot_next;
        pend_slot_reg <= pend_slot_next;
        pend_id_reg   <= pend_id_next;
        res_reg       <= res_next;
        q_slot_reg    <= SI_W'(rd_slot);
    end

    // in-use rows, read at the head command's group
    always_ff @(posedge clk)
    begin
        if (row_we)
        begin
            row_mem[gi_reg] <= row_wdata;
        end
        row_q_reg <= row_mem[cmd_head.cmd.grp[GI_W-1:0]];
    end

    // member ids, one read and one write port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= id_reg;
        end
        mem_q_reg <= mem[rd_addr];
    end

endmodule

// ===== src/group_membership_fanout_table.sv =====
// Group membership fanout table. Keeps GROUPS multicast groups of SLOTS member
// slots each. A request (join, leave, send) enters through a queue-style push
// port and its results leave through a queue-style pop port; a short command
// queue sits between the request front end and the table sequencer, and a
// result queue decouples the sequencer from the consumer. Requests are served
// one at a time. The member ids sit in a single-port-read memory that is
// walked one slot per cycle (the fanout walk pauses on a full result queue).
// A bad group skips the walk; a join or leave walks to the match (all slots
// if none); a send finds the sender, then walks all slots again, emitting at
// most one destination per cycle when the result queue has room. After reset
// every slot is free at once (one valid bit per group row); no clearing pass.
// Depends on gmft_pkg, gmft_front, gmft_back and gmft_fifo.
module group_membership_fanout_table #(
    parameter int GROUPS  = gmft_pkg::GROUPS_DEF,
    parameter int SLOTS   = gmft_pkg::SLOTS_DEF,
    parameter int ID_BITS = gmft_pkg::ID_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic [gmft_pkg::REQ_W-1:0]     req_type,
    input  logic [gmft_pkg::GRP_W-1:0]     group_index,
    input  logic [gmft_pkg::ID_W-1:0]      member_id,
    output logic                           empty,
    input  logic                           pop,
    output logic [gmft_pkg::STATUS_W-1:0]  status,
    output logic                           dest_valid,
    output logic [gmft_pkg::ID_W-1:0]      dest_id,
    output logic [gmft_pkg::SLOT_W-1:0]    slot_index,
    output logic                           last
);

    import gmft_pkg::*;

    cmd_head_t           cmd_head;
    logic                cmd_pop;
    logic                res_full;
    logic                res_push;
    res_t                res_data;
    logic [RES_BITS-1:0] res_rdata;
    res_t                res_head;

    // request front end with command queue
    gmft_front #(
        .GROUPS  (GROUPS),
        .ID_BITS (ID_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .req_type    (req_type),
        .group_index (group_index),
        .member_id   (member_id),
        .cmd_pop     (cmd_pop),
        .cmd_head    (cmd_head)
    );

    // table sequencer
    gmft_back #(
        .GROUPS  (GROUPS),
        .SLOTS   (SLOTS),
        .ID_BITS (ID_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_head (cmd_head),
        .cmd_pop  (cmd_pop),
        .res_full (res_full),
        .res_push (res_push),
        .res_data (res_data)
    );

    // result queue
    gmft_fifo #(
        .WIDTH (RES_BITS),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_data),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_rdata),
        .empty (empty)
    );

    assign res_head   = res_rdata;
    assign status     = res_head.status;
    assign dest_valid = res_head.dest_valid;
    assign dest_id    = res_head.dest_id;
    assign slot_index = res_head.slot_index;
    assign last       = res_head.last;

endmodule
